/* hdl/tpq_pkg.sv */
`default_nettype none

package tpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int LEVELS      = 3;

    localparam int IN_VAL_W  = 32;
    localparam int PRIO_IN_W = 3;
    localparam int OUT_VAL_W = 32;
    localparam int PRIO_OUT_W = 2;
    localparam int STATUS_W  = 3;

    localparam int LVL_W  = 2;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_INVALID  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    // circular pointer step
    function automatic t_ptr next_ptr(input t_ptr p);
        t_ptr r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tpq_cmd_if.sv */
`default_nettype none

interface tpq_cmd_if import tpq_pkg::*; ;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic signed [IN_VAL_W-1:0]  value_in;
    logic [PRIO_IN_W-1:0]        priority_in;

    modport source (output valid, func, value_in, priority_in, input ready);
    modport sink   (input valid, func, value_in, priority_in, output ready);
endinterface

`default_nettype wire

/* hdl/tpq_res_if.sv */
`default_nettype none

interface tpq_res_if import tpq_pkg::*; ;
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [OUT_VAL_W-1:0] value_out;
    logic [PRIO_OUT_W-1:0]       priority_out;

    modport source (output valid, status, value_out, priority_out, input ready);
    modport sink   (input valid, status, value_out, priority_out, output ready);
endinterface

`default_nettype wire

/* hdl/three_level_priority_queue.sv */
// pipeline: an accepted transaction passes the decision stage and ram read, then the
// output register; throughput: one transaction per cycle unless the output stalls,
// each touches one queue slot and its pointers
// reset (i_rst_n, synchronous, active low) empties all three queues and the pipeline;
// the queue ram itself is not cleared, an entry is only read after it was written
`default_nettype none

module three_level_priority_queue import tpq_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    tpq_cmd_if.sink   i_cmd,
    tpq_res_if.source o_res
);

    // queue ram: address is {level, slot}, one region per level
    logic [VALUE_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    // per-level head/tail pointers and fill counts
    t_ptr r_head  [LEVELS];
    t_ptr r_tail  [LEVELS];
    t_cnt r_count [LEVELS];

    // decision stage: status known, ram read in flight for removes
    logic                  r_s1_valid;
    t_status               r_s1_status;
    logic [PRIO_OUT_W-1:0] r_s1_prio;

    // output register
    logic                        r_o_valid;
    t_status                     r_o_status;
    logic signed [OUT_VAL_W-1:0] r_o_value;
    logic [PRIO_OUT_W-1:0]       r_o_prio;

    logic       in_accept;
    logic       s1_adv;
    logic       prio_ok;
    logic [LVL_W-1:0] lvl_ins;
    logic [LVL_W-1:0] lvl_rem;
    logic       found;
    t_cnt       cnt_ins;
    logic       do_ins;
    logic       do_rem;
    t_status    n_s1_status;
    logic [PRIO_OUT_W-1:0] n_s1_prio;

    // handshake: the decision stage moves on whenever the output register is
    // free or being drained, and a new transaction enters behind it
    assign s1_adv       = r_s1_valid && (!r_o_valid || o_res.ready);
    assign i_cmd.ready  = !r_s1_valid || s1_adv;
    assign in_accept    = i_cmd.valid && i_cmd.ready;

    // decode and pick the target level
    always_comb begin
        prio_ok = (i_cmd.priority_in != PRIO_IN_W'(0))
               && (i_cmd.priority_in <= PRIO_IN_W'(LEVELS));
        lvl_ins = LVL_W'(i_cmd.priority_in - PRIO_IN_W'(1));
        cnt_ins = '0;
        if (prio_ok) begin
            cnt_ins = r_count[lvl_ins];
        end

        // strict priority: lowest level number that holds anything wins
        found   = 1'b0;
        lvl_rem = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                found   = 1'b1;
                lvl_rem = LVL_W'(l);
            end
        end

        do_ins      = 1'b0;
        do_rem      = 1'b0;
        n_s1_prio   = '0;
        n_s1_status = ST_EMPTY;
        if (i_cmd.func == FUNC_INSERT) begin
            if (!prio_ok) begin
                n_s1_status = ST_INVALID;
            end else if (cnt_ins == CNT_W'(QUEUE_DEPTH)) begin
                n_s1_status = ST_FULL;
            end else begin
                n_s1_status = ST_INSERTED;
                do_ins      = in_accept;
            end
        end else begin
            if (found) begin
                n_s1_status = ST_REMOVED;
                n_s1_prio   = PRIO_OUT_W'(lvl_rem) + PRIO_OUT_W'(1);
                do_rem      = in_accept;
            end else begin
                n_s1_status = ST_EMPTY;
            end
        end
    end

    // ram: one write and one registered read per cycle; a remove only reads
    // slots whose write committed at an earlier edge, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            r_mem[{lvl_ins, r_tail[lvl_ins]}] <= VALUE_WIDTH'($unsigned(i_cmd.value_in));
        end
        if (do_rem) begin
            r_rd_data <= r_mem[{lvl_rem, r_head[lvl_rem]}];
        end
    end

    // pointers and counts update at accept so the next transaction sees them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            if (do_ins) begin
                r_tail[lvl_ins]  <= next_ptr(r_tail[lvl_ins]);
                r_count[lvl_ins] <= r_count[lvl_ins] + CNT_W'(1);
            end
            if (do_rem) begin
                r_head[lvl_rem]  <= next_ptr(r_head[lvl_rem]);
                r_count[lvl_rem] <= r_count[lvl_rem] - CNT_W'(1);
            end
        end
    end

    // decision stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_status <= n_s1_status;
            r_s1_prio   <= n_s1_prio;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_status <= r_s1_status;
            r_o_prio   <= r_s1_prio;
            if (r_s1_status == ST_REMOVED) begin
                r_o_value <= $signed(OUT_VAL_W'(r_rd_data));
            end else begin
                r_o_value <= '0;
            end
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.status       = r_o_status;
    assign o_res.value_out    = r_o_value;
    assign o_res.priority_out = r_o_prio;

    // a removed value always names its level, anything else carries zeros
    a_removed_has_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_REMOVED) |-> (r_o_prio != '0))
        else $error("removed result without a level");

    a_other_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_REMOVED) |-> (r_o_prio == '0 && r_o_value == '0))
        else $error("non-remove result carries data");

    // counts never pass the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= CNT_W'(QUEUE_DEPTH)) && (r_count[1] <= CNT_W'(QUEUE_DEPTH))
        && (r_count[2] <= CNT_W'(QUEUE_DEPTH)))
        else $error("level count above queue depth");

    // a stalled remove in the decision stage keeps its read data
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_status == ST_REMOVED && !s1_adv)
        |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("read data lost while stalled");

endmodule

`default_nettype wire
